[rtl/dvs_pkg.sv]
// Package: shared constants for the 3D voxel line stepper.
`timescale 1ns / 1ps
`default_nettype none
package dvs_pkg;
  localparam int MAX_SPAN_DEF   = 64;
  localparam int COORD_BITS_DEF = 10;
  localparam int NUM_AXES       = 3;
endpackage
`default_nettype wire

[rtl/dda_line_voxel_stepper_3d_top.sv]
// Top level: 3D integer DDA voxel line stepper with step sequencer.
`timescale 1ns / 1ps
`default_nettype none
// A ray is taken when start is high and busy is low. A ray whose span m (largest
// absolute axis delta) lies in 2..MAX_SPAN gives m-1 results, one per cycle. Busy
// stays high while the sequencer runs. Each result is registered at the end of
// its busy cycle. The last result overlaps the first cycle in which a new ray
// can be taken. A ray of span 0 or 1 gives nothing. A ray longer than MAX_SPAN
// gives a single too_long result in the cycle after the transfer. Neither of
// these raises busy. The rate is set by the per-axis step units, which advance
// each axis by one remainder update per cycle under the step sequencer. Each
// result appears for exactly one cycle with strobe high; the receiver cannot
// stall the block.
module dda_line_voxel_stepper_3d_top #(
  parameter int MAX_SPAN   = dvs_pkg::MAX_SPAN_DEF,
  parameter int COORD_BITS = dvs_pkg::COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [COORD_BITS-1:0] start_x,
  input  wire logic [COORD_BITS-1:0] start_y,
  input  wire logic [COORD_BITS-1:0] start_z,
  input  wire logic [COORD_BITS-1:0] end_x,
  input  wire logic [COORD_BITS-1:0] end_y,
  input  wire logic [COORD_BITS-1:0] end_z,
  output logic                       strobe,
  output logic      [COORD_BITS-1:0] floor_x,
  output logic      [COORD_BITS-1:0] floor_y,
  output logic      [COORD_BITS-1:0] floor_z,
  output logic      [COORD_BITS-1:0] ceil_x,
  output logic      [COORD_BITS-1:0] ceil_y,
  output logic      [COORD_BITS-1:0] ceil_z,
  output logic                       last,
  output logic                       too_long
);
  import dvs_pkg::*;

  localparam int SPAN_BITS = $clog2(MAX_SPAN + 1);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t state;

  logic [NUM_AXES-1:0][COORD_BITS-1:0] start_pos;
  logic [NUM_AXES-1:0][COORD_BITS-1:0] end_pos;
  logic [NUM_AXES-1:0][SPAN_BITS:0]    setup_delta;
  logic [SPAN_BITS-1:0]                setup_span;
  logic                                setup_long;
  logic                                setup_short;

  logic [COORD_BITS-1:0] pos       [NUM_AXES];
  logic [SPAN_BITS-1:0]  rem       [NUM_AXES];
  logic [SPAN_BITS:0]    delta     [NUM_AXES];
  logic [COORD_BITS-1:0] pos_next  [NUM_AXES];
  logic [SPAN_BITS-1:0]  rem_next  [NUM_AXES];
  logic [COORD_BITS-1:0] pos_ceil  [NUM_AXES];
  logic [COORD_BITS-1:0] floor_q   [NUM_AXES];
  logic [COORD_BITS-1:0] ceil_q    [NUM_AXES];
  logic [SPAN_BITS-1:0]  span;
  logic [SPAN_BITS-1:0]  step;
  logic                  final_step;

  assign start_pos = {start_z, start_y, start_x};
  assign end_pos   = {end_z, end_y, end_x};

  dvs_setup #(
    .MAX_SPAN  (MAX_SPAN),
    .COORD_BITS(COORD_BITS),
    .SPAN_BITS (SPAN_BITS)
  ) u_setup (
    .start_pos(start_pos),
    .end_pos  (end_pos),
    .delta    (setup_delta),
    .span     (setup_span),
    .too_long (setup_long),
    .short_ray(setup_short)
  );

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    dvs_axis_step #(
      .COORD_BITS(COORD_BITS),
      .SPAN_BITS (SPAN_BITS)
    ) u_step (
      .pos     (pos[a]),
      .rem     (rem[a]),
      .delta   (delta[a]),
      .span    (span),
      .pos_next(pos_next[a]),
      .rem_next(rem_next[a]),
      .pos_ceil(pos_ceil[a])
    );
  end

  assign final_step = (step == SPAN_BITS'(span - 1'b1));
  assign busy       = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            for (int a = 0; a < NUM_AXES; a++) begin
              pos[a]   <= start_pos[a];
              rem[a]   <= '0;
              delta[a] <= setup_delta[a];
            end
            span <= setup_span;
            step <= SPAN_BITS'(1);
            if (setup_long) begin
              strobe   <= 1'b1;
              last     <= 1'b1;
              too_long <= 1'b1;
              for (int a = 0; a < NUM_AXES; a++) begin
                floor_q[a] <= '0;
                ceil_q[a]  <= '0;
              end
            end else if (!setup_short) begin
              state <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          for (int a = 0; a < NUM_AXES; a++) begin
            pos[a]     <= pos_next[a];
            rem[a]     <= rem_next[a];
            floor_q[a] <= pos_next[a];
            ceil_q[a]  <= pos_ceil[a];
          end
          step     <= SPAN_BITS'(step + 1'b1);
          strobe   <= 1'b1;
          last     <= final_step;
          too_long <= 1'b0;
          if (final_step) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign floor_x = floor_q[0];
  assign floor_y = floor_q[1];
  assign floor_z = floor_q[2];
  assign ceil_x  = ceil_q[0];
  assign ceil_y  = ceil_q[1];
  assign ceil_z  = ceil_q[2];
endmodule
`default_nettype wire

[rtl/dvs_setup.sv]
// Ray setup: per-axis deltas, span and short/long classification.
`timescale 1ns / 1ps
`default_nettype none
module dvs_setup #(
  parameter int MAX_SPAN   = dvs_pkg::MAX_SPAN_DEF,
  parameter int COORD_BITS = dvs_pkg::COORD_BITS_DEF,
  parameter int SPAN_BITS  = $clog2(MAX_SPAN + 1)
) (
  input  wire logic [dvs_pkg::NUM_AXES-1:0][COORD_BITS-1:0] start_pos,
  input  wire logic [dvs_pkg::NUM_AXES-1:0][COORD_BITS-1:0] end_pos,
  output logic      [dvs_pkg::NUM_AXES-1:0][SPAN_BITS:0]    delta,
  output logic      [SPAN_BITS-1:0]                         span,
  output logic                                              too_long,
  output logic                                              short_ray
);
  import dvs_pkg::*;

  localparam int AW = ((COORD_BITS > SPAN_BITS) ? COORD_BITS : SPAN_BITS) + 1;

  logic signed [AW-1:0] diff [NUM_AXES];
  logic        [AW-1:0] mag  [NUM_AXES];
  logic        [AW-1:0] mag_max;

  always_comb begin
    mag_max = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      diff[a] = signed'(AW'(end_pos[a])) - signed'(AW'(start_pos[a]));
      mag[a]  = diff[a][AW-1] ? AW'(-diff[a]) : AW'(diff[a]);
      delta[a] = diff[a][SPAN_BITS:0];
      if (mag[a] > mag_max) begin
        mag_max = mag[a];
      end
    end
  end

  assign too_long  = (mag_max > AW'(MAX_SPAN));
  assign span      = mag_max[SPAN_BITS-1:0];
  assign short_ray = !too_long && (mag_max < AW'(2));
endmodule
`default_nettype wire

[rtl/dvs_axis_step.sv]
// Step unit: advances one axis by its delta in units of 1/span voxel.
`timescale 1ns / 1ps
`default_nettype none
module dvs_axis_step #(
  parameter int COORD_BITS = dvs_pkg::COORD_BITS_DEF,
  parameter int SPAN_BITS  = 7
) (
  input  wire logic [COORD_BITS-1:0] pos,
  input  wire logic [SPAN_BITS-1:0]  rem,
  input  wire logic [SPAN_BITS:0]    delta,
  input  wire logic [SPAN_BITS-1:0]  span,
  output logic      [COORD_BITS-1:0] pos_next,
  output logic      [SPAN_BITS-1:0]  rem_next,
  output logic      [COORD_BITS-1:0] pos_ceil
);
  localparam int RW = SPAN_BITS + 2;

  logic signed [RW-1:0] sum;
  logic signed [RW-1:0] span_s;
  logic signed [RW-1:0] fixed;

  always_comb begin
    span_s   = signed'({2'b00, span});
    sum      = signed'({2'b00, rem}) + signed'({delta[SPAN_BITS], delta});
    fixed    = sum;
    pos_next = pos;
    if (sum >= span_s) begin
      fixed    = sum - span_s;
      pos_next = pos + 1'b1;
    end else if (sum < 0) begin
      fixed    = sum + span_s;
      pos_next = pos - 1'b1;
    end
    rem_next = fixed[SPAN_BITS-1:0];
    pos_ceil = pos_next + COORD_BITS'(rem_next != '0);
  end
endmodule
`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps
// Testbench for the 3D DDA voxel line stepper: directed rays, then random rays, checked per step.
module tb;
  import dvs_pkg::*;

  localparam int SPAN_MAX      = MAX_SPAN_DEF;
  localparam int CB            = COORD_BITS_DEF;
  localparam int COORD_TOP     = (1 << CB) - 1;
  localparam int DIRECTED_RAYS = 21;
  localparam int RANDOM_RAYS   = 290;
  localparam int CYCLE_LIMIT   = 200000;

  typedef enum logic [1:0] {KIND_STEPS, KIND_NO_STEPS, KIND_TOO_LONG} ray_kind_t;

  typedef struct packed {
    ray_kind_t     kind;
    logic [CB-1:0] sx, sy, sz, ex, ey, ez;
  } ray_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][CB-1:0] lo_vox;
    logic [NUM_AXES-1:0][CB-1:0] hi_vox;
    logic                        last;
    logic                        too_long;
  } voxel_step_t;

  localparam voxel_step_t TOO_LONG_STEP = {{2 * NUM_AXES * CB{1'b0}}, 2'b11};

  localparam ray_t DIRECTED [DIRECTED_RAYS] = '{
    {KIND_NO_STEPS, 10'd0,    10'd0,    10'd0,    10'd0,    10'd0,    10'd0},
    {KIND_NO_STEPS, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023},
    {KIND_NO_STEPS, 10'd0,    10'd0,    10'd0,    10'd1,    10'd1,    10'd1},
    {KIND_NO_STEPS, 10'd1023, 10'd1023, 10'd1023, 10'd1022, 10'd1023, 10'd1022},
    {KIND_TOO_LONG, 10'd0,    10'd0,    10'd0,    10'd65,   10'd0,    10'd0},
    {KIND_TOO_LONG, 10'd0,    10'd0,    10'd0,    10'd1023, 10'd1023, 10'd1023},
    {KIND_TOO_LONG, 10'd1023, 10'd0,    10'd1023, 10'd0,    10'd1023, 10'd0},
    {KIND_TOO_LONG, 10'd0,    10'd0,    10'd1023, 10'd0,    10'd0,    10'd958},
    {KIND_STEPS,    10'd0,    10'd0,    10'd0,    10'd64,   10'd0,    10'd0},
    {KIND_STEPS,    10'd1023, 10'd1023, 10'd1023, 10'd959,  10'd1000, 10'd1023},
    {KIND_STEPS,    10'd0,    10'd0,    10'd0,    10'd2,    10'd1,    10'd0},
    {KIND_STEPS,    10'd5,    10'd5,    10'd5,    10'd3,    10'd7,    10'd5},
    {KIND_STEPS,    10'd0,    10'd0,    10'd0,    10'd0,    10'd0,    10'd5},
    {KIND_STEPS,    10'd3,    10'd0,    10'd0,    10'd0,    10'd0,    10'd3},
    {KIND_STEPS,    10'd100,  10'd200,  10'd300,  10'd140,  10'd180,  10'd310},
    {KIND_STEPS,    10'd0,    10'd1023, 10'd0,    10'd64,   10'd959,  10'd64},
    {KIND_STEPS,    10'd500,  10'd10,   10'd7,    10'd510,  10'd60,   10'd0},
    {KIND_STEPS,    10'd1023, 10'd0,    10'd512,  10'd1000, 10'd5,    10'd575},
    {KIND_STEPS,    10'd0,    10'd0,    10'd0,    10'd1,    10'd2,    10'd63},
    {KIND_STEPS,    10'd1022, 10'd1,    10'd1,    10'd1019, 10'd0,    10'd3},
    {KIND_STEPS,    10'd960,  10'd63,   10'd1023, 10'd1023, 10'd0,    10'd960}
  };

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  ray_t          pending_ray = '0;
  logic          busy, strobe, last, too_long;
  logic [CB-1:0] floor_x, floor_y, floor_z, ceil_x, ceil_y, ceil_z;

  voxel_step_t   expected_steps[$];
  int            mismatches = 0;
  int            cycles = 0;
  string         axis_name[3] = '{"x", "y", "z"};

  always #4 clk = ~clk;

  dda_line_voxel_stepper_3d_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .start_x  (pending_ray.sx),
    .start_y  (pending_ray.sy),
    .start_z  (pending_ray.sz),
    .end_x    (pending_ray.ex),
    .end_y    (pending_ray.ey),
    .end_z    (pending_ray.ez),
    .strobe   (strobe),
    .floor_x  (floor_x),
    .floor_y  (floor_y),
    .floor_z  (floor_z),
    .ceil_x   (ceil_x),
    .ceil_y   (ceil_y),
    .ceil_z   (ceil_z),
    .last     (last),
    .too_long (too_long)
  );

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  function automatic void queue_step(voxel_step_t v);
    expected_steps.insert(expected_steps.size(), v);
  endfunction

  function automatic void predict_ray_steps(ray_t r);
    int          org[3];
    int          dst[3];
    int          dlt[3];
    int          m, p, a, s;
    voxel_step_t v;
    org = '{r.sx, r.sy, r.sz};
    dst = '{r.ex, r.ey, r.ez};
    m = 0;
    for (a = 0; a < 3; a++) begin
      dlt[a] = dst[a] - org[a];
      if (dlt[a] > m) m = dlt[a];
      if (-dlt[a] > m) m = -dlt[a];
    end
    if (m > SPAN_MAX) begin
      v = '0;
      v.last = 1'b1;
      v.too_long = 1'b1;
      queue_step(v);
    end else begin
      for (s = 1; s < m; s++) begin
        v = '0;
        for (a = 0; a < 3; a++) begin
          p = org[a] * m + s * dlt[a];
          v.lo_vox[a] = CB'(p / m);
          v.hi_vox[a] = CB'((p + m - 1) / m);
        end
        v.last = (s == m - 1);
        queue_step(v);
      end
    end
  endfunction

  function automatic ray_t random_ray();
    ray_t r;
    int   org[3];
    int   dst[3];
    int   mode, m, lead, a, d;
    mode = $urandom_range(0, 9);
    for (a = 0; a < 3; a++) org[a] = $urandom_range(0, COORD_TOP);
    if (mode == 0) begin
      for (a = 0; a < 3; a++) dst[a] = $urandom_range(0, COORD_TOP);
    end else begin
      if (mode == 1) m = $urandom_range(0, 1);
      else if (mode < 6) m = $urandom_range(2, 8);
      else if (mode < 9) m = $urandom_range(2, SPAN_MAX);
      else m = SPAN_MAX + $urandom_range(0, 1);
      lead = $urandom_range(0, 2);
      for (a = 0; a < 3; a++) begin
        d = (a == lead) ? m : $urandom_range(0, m);
        if ($urandom_range(0, 1) == 1) d = -d;
        dst[a] = org[a] + d;
        if (dst[a] < 0 || dst[a] > COORD_TOP) dst[a] = org[a] - d;
      end
    end
    r.kind = KIND_STEPS;
    r.sx = CB'(org[0]);
    r.sy = CB'(org[1]);
    r.sz = CB'(org[2]);
    r.ex = CB'(dst[0]);
    r.ey = CB'(dst[1]);
    r.ez = CB'(dst[2]);
    return r;
  endfunction

  task automatic send_ray(ray_t r);
    pending_ray <= r;
    start <= 1'b1;
    do @(posedge clk); while (!(start && !busy));
  endtask

  // transfer in, predict, and check each result against the oldest expectation
  always @(posedge clk) begin
    voxel_step_t got, want;
    int          a;
    if (!rst && start && !busy) begin
      case (pending_ray.kind)
        KIND_TOO_LONG: queue_step(TOO_LONG_STEP);
        KIND_NO_STEPS: ;
        default:       predict_ray_steps(pending_ray);
      endcase
    end
    if (!rst && strobe) begin
      got = {{floor_z, floor_y, floor_x}, {ceil_z, ceil_y, ceil_x}, last, too_long};
      if (expected_steps.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = expected_steps.pop_front();
        for (a = 0; a < 3; a++) begin
          if (got.lo_vox[a] !== want.lo_vox[a])
            report_mismatch($sformatf("floor_%s got %0d want %0d", axis_name[a],
                                      got.lo_vox[a], want.lo_vox[a]));
          if (got.hi_vox[a] !== want.hi_vox[a])
            report_mismatch($sformatf("ceil_%s got %0d want %0d", axis_name[a],
                                      got.hi_vox[a], want.hi_vox[a]));
        end
        if (got.last !== want.last)
          report_mismatch($sformatf("last got %0b want %0b", got.last, want.last));
        if (got.too_long !== want.too_long)
          report_mismatch($sformatf("too_long got %0b want %0b", got.too_long, want.too_long));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    ray_t r;
    int   n, burst_left;
    burst_left = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (n = 0; n < DIRECTED_RAYS + RANDOM_RAYS; n++) begin
      r = (n < DIRECTED_RAYS) ? DIRECTED[n] : random_ray();
      if (n == DIRECTED_RAYS + RANDOM_RAYS / 2) begin
        // hold until every pending step has drained
        start <= 1'b0;
        do @(posedge clk); while (expected_steps.size() != 0);
      end else if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        if ($urandom_range(0, 3) != 0) begin
          start <= 1'b0;
          if ($urandom_range(0, 4) == 0) repeat ($urandom_range(7, 70)) @(posedge clk);
          else repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
      if (burst_left > 0) burst_left--;
      send_ray(r);
    end
    start <= 1'b0;
    do @(posedge clk); while (expected_steps.size() != 0);
    repeat (SPAN_MAX + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
